// File: rtl/qpd_pkg.sv
// shared types, character codes and helpers for the quoted-printable body decoder
`timescale 1ns / 1ps

package qpd_pkg;

	localparam logic [7:0] CH_LF         = 8'h0A;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_ZERO       = 8'h30;
	localparam logic [7:0] CH_NINE       = 8'h39;
	localparam logic [7:0] CH_LT         = 8'h3C;
	localparam logic [7:0] CH_EQ         = 8'h3D;
	localparam logic [7:0] CH_GT         = 8'h3E;
	localparam logic [7:0] CH_CAP_A      = 8'h41;
	localparam logic [7:0] HEX_LETTER_OFS = 8'd55;

	localparam int unsigned MAX_RES = 4;

	typedef enum logic [1:0] {
		ESC_IDLE = 2'd0,
		ESC_EQ   = 2'd1,
		ESC_EQEQ = 2'd2,
		ESC_HIGH = 2'd3
	} esc_t;

	typedef enum logic [1:0] {
		HOLD_NONE = 2'd0,
		HOLD_EQ   = 2'd1,
		HOLD_PAIR = 2'd2
	} hold_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_has_byte;
		logic       out_last;
	} res_t;

	typedef struct packed {
		logic       inside_tag;
		logic       text_since_tag;
		hold_t      held_count;
		logic [7:0] held_second;
		esc_t       escape_phase;
		logic [7:0] high_part;
	} st_t;

	localparam st_t ST_RESET = '{
		inside_tag:     1'b0,
		text_since_tag: 1'b0,
		held_count:     HOLD_NONE,
		held_second:    8'h00,
		escape_phase:   ESC_IDLE,
		high_part:      8'h00
	};

	// up to four decoded bytes caused by one input item
	typedef struct packed {
		logic [2:0]           cnt;
		logic [MAX_RES-1:0][7:0] bytes;
		logic                 last;
	} bundle_t;

	typedef struct packed {
		st_t        s;
		logic [2:0] cnt;
		logic [MAX_RES-1:0][7:0] bytes;
	} work_t;

	function automatic logic [7:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			v = c - CH_ZERO;
		end else begin
			v = c - HEX_LETTER_OFS;
		end
		return v;
	endfunction

endpackage

// File: rtl/qpd_front.sv
// front part: tag stripping, soft break removal and quoted-printable decode per item
`timescale 1ns / 1ps

module qpd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            src_valid,
	output logic            src_ready,
	input  qpd_pkg::in_t    src_item,
	output logic            push_valid,
	input  logic            push_ready,
	output qpd_pkg::bundle_t push_data
);

	qpd_pkg::st_t   state_q;
	qpd_pkg::work_t w;
	logic           accept;

	function automatic qpd_pkg::work_t put_byte(input qpd_pkg::work_t wi, input logic [7:0] c);
		qpd_pkg::work_t r;
		r = wi;
		if (r.cnt < 3'd4) begin
			r.bytes[r.cnt[1:0]] = c;
			r.cnt = r.cnt + 3'd1;
		end
		return r;
	endfunction

	function automatic qpd_pkg::work_t decode_feed(input qpd_pkg::work_t wi, input logic [7:0] c);
		qpd_pkg::work_t r;
		logic [7:0]     hv;
		r  = wi;
		hv = qpd_pkg::hex_value(c);
		case (r.s.escape_phase)
			qpd_pkg::ESC_IDLE: begin
				if (c == qpd_pkg::CH_EQ) begin
					r.s.escape_phase = qpd_pkg::ESC_EQ;
				end else begin
					r = put_byte(r, c);
				end
			end
			qpd_pkg::ESC_EQ: begin
				if (c == qpd_pkg::CH_EQ) begin
					r.s.escape_phase = qpd_pkg::ESC_EQEQ;
				end else begin
					r.s.high_part    = {hv[3:0], 4'h0};
					r.s.escape_phase = qpd_pkg::ESC_HIGH;
				end
			end
			qpd_pkg::ESC_EQEQ: begin
				r.s.high_part    = {hv[3:0], 4'h0};
				r.s.escape_phase = qpd_pkg::ESC_HIGH;
			end
			default: begin
				r = put_byte(r, r.s.high_part + hv);
				r.s.escape_phase = qpd_pkg::ESC_IDLE;
			end
		endcase
		return r;
	endfunction

	function automatic qpd_pkg::work_t emit_text(input qpd_pkg::work_t wi, input logic [7:0] c);
		qpd_pkg::work_t r;
		r = wi;
		r.s.text_since_tag = 1'b1;
		return decode_feed(r, c);
	endfunction

	function automatic qpd_pkg::work_t process_fresh(input qpd_pkg::work_t wi, input logic [7:0] c);
		qpd_pkg::work_t r;
		r = wi;
		if (r.s.inside_tag) begin
			r.s.text_since_tag = 1'b0;
			if (c == qpd_pkg::CH_GT) begin
				r.s.inside_tag = 1'b0;
			end
		end else if (c == qpd_pkg::CH_LT) begin
			if (r.s.text_since_tag) begin
				r.s.text_since_tag = 1'b0;
				r = decode_feed(r, qpd_pkg::CH_LF);
			end
			r.s.inside_tag = 1'b1;
		end else if (c == qpd_pkg::CH_EQ) begin
			r.s.held_count = qpd_pkg::HOLD_EQ;
		end else begin
			r = emit_text(r, c);
		end
		return r;
	endfunction

	function automatic qpd_pkg::work_t flush_held(input qpd_pkg::work_t wi);
		qpd_pkg::work_t r;
		r = wi;
		case (r.s.held_count)
			qpd_pkg::HOLD_EQ: begin
				r = emit_text(r, qpd_pkg::CH_EQ);
			end
			qpd_pkg::HOLD_PAIR: begin
				r = emit_text(r, qpd_pkg::CH_EQ);
				r = emit_text(r, r.s.held_second);
			end
			default: begin
			end
		endcase
		r.s.held_count = qpd_pkg::HOLD_NONE;
		return r;
	endfunction

	// one byte through the whole chain
	always_comb begin
		w.s     = state_q;
		w.cnt   = 3'd0;
		w.bytes = '0;
		case (state_q.held_count)
			qpd_pkg::HOLD_EQ: begin
				if (src_item.in_byte == qpd_pkg::CH_CR || src_item.in_byte == qpd_pkg::CH_ZERO) begin
					w.s.held_second = src_item.in_byte;
					w.s.held_count  = qpd_pkg::HOLD_PAIR;
				end else begin
					w = flush_held(w);
					w = process_fresh(w, src_item.in_byte);
				end
			end
			qpd_pkg::HOLD_PAIR: begin
				if ((state_q.held_second == qpd_pkg::CH_CR && src_item.in_byte == qpd_pkg::CH_LF) ||
				    (state_q.held_second == qpd_pkg::CH_ZERO &&
				     src_item.in_byte == qpd_pkg::CH_CAP_A)) begin
					w.s.held_count  = qpd_pkg::HOLD_NONE;
					w.s.held_second = 8'h00;
				end else begin
					w = flush_held(w);
					w = process_fresh(w, src_item.in_byte);
				end
			end
			default: begin
				w = process_fresh(w, src_item.in_byte);
			end
		endcase
		if (src_item.in_last) begin
			w = flush_held(w);
		end
	end

	assign src_ready       = push_ready;
	assign accept          = src_valid && src_ready;
	assign push_valid      = src_valid && ((w.cnt != 3'd0) || src_item.in_last);
	assign push_data.cnt   = w.cnt;
	assign push_data.bytes = w.bytes;
	assign push_data.last  = src_item.in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qpd_pkg::ST_RESET;
		end else if (accept) begin
			state_q <= src_item.in_last ? qpd_pkg::ST_RESET : w.s;
		end
	end

	// end of region leaves the state clean for the next one
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && src_item.in_last) |=> (state_q == qpd_pkg::ST_RESET))
		else $error("state not cleared after end of region");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid |-> (w.cnt <= 3'd4))
		else $error("more than four bytes from one item");

endmodule

// File: rtl/qpd_queue.sv
// two-entry queue of result bundles between front and back
`timescale 1ns / 1ps

module qpd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  qpd_pkg::bundle_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output qpd_pkg::bundle_t pop_data
);

	qpd_pkg::bundle_t slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

// File: rtl/qpd_back.sv
// back part: splits each bundle into result items behind an output register
`timescale 1ns / 1ps

module qpd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  qpd_pkg::bundle_t pop_data,
	output logic             dst_valid,
	input  logic             dst_ready,
	output qpd_pkg::res_t    dst_item
);

	logic [1:0]    idx_q;
	logic          out_valid_q;
	qpd_pkg::res_t out_q;
	logic          load;
	logic          done;
	logic          take;

	// output register is free or being emptied this cycle
	assign load      = !out_valid_q || dst_ready;
	assign done      = (pop_data.cnt == 3'd0) || (({1'b0, idx_q} + 3'd1) == pop_data.cnt);
	assign take      = load && pop_valid;
	assign pop_ready = load && done;
	assign dst_valid = out_valid_q;
	assign dst_item  = out_q;

	always_ff @(posedge clk) begin
		if (take) begin
			out_q.out_byte     <= (pop_data.cnt != 3'd0) ? pop_data.bytes[idx_q] : 8'h00;
			out_q.out_has_byte <= (pop_data.cnt != 3'd0);
			out_q.out_last     <= pop_data.last && done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= pop_valid;
			end
			if (take) begin
				idx_q <= done ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	a_idx_in_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid |-> ((idx_q == 2'd0) || ({1'b0, idx_q} < pop_data.cnt)))
		else $error("item index past end of bundle");

endmodule

// File: rtl/html_text_qp_body_decoder_core.sv
// top level of the html text extractor with quoted-printable body decoding
`timescale 1ns / 1ps

// channel   signals                           item
// -------   -------------------------------   -----------------------------------------
// src       src_valid / src_ready / src_item   raw body byte + last flag
// dst       dst_valid / dst_ready / dst_item   decoded byte, has-byte flag, last flag
//
// one input item is taken per cycle while the bundle queue has room; the front
// part decodes the whole byte in that cycle and hands up to four bytes onward
// the back part sends one result item per cycle from its output register while
// dst_ready is high, so an item with n results (n from 1 to 4) holds the result side
// until all n are taken; items without bytes or last flag never reach the back part
// arst_n clears the decoder state, the queue and the output valid
// a stalled dst fills the two-entry queue, after which src_ready drops

module html_text_qp_body_decoder_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          src_valid,
	output logic          src_ready,
	input  qpd_pkg::in_t  src_item,
	output logic          dst_valid,
	input  logic          dst_ready,
	output qpd_pkg::res_t dst_item
);

	// front to queue
	logic             push_valid;
	logic             push_ready;
	qpd_pkg::bundle_t push_data;

	// queue to back
	logic             pop_valid;
	logic             pop_ready;
	qpd_pkg::bundle_t pop_data;

	// markup, soft break and escape handling, one byte per cycle while the queue has room
	qpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_valid  (src_valid),
		.src_ready  (src_ready),
		.src_item   (src_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decouples the byte-rate front from the item-rate back
	qpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// serializes each bundle into result items
	qpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_item  (dst_item)
	);

endmodule
